// ----- src/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types and constants for the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam int unsigned HEX_BITS = 4;

   typedef enum logic [3:0] {
      PH_SIZE  = 4'b0001,
      PH_DATA  = 4'b0010,
      PH_AFTER = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      digits_ended;
      logic      cr_seen;
      logic      overflow;
   } flags_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       byte_consumed;
      logic       finished;
      logic       size_overflow;
   } result_type;

   typedef struct packed {
      logic                is_hex;
      logic [HEX_BITS-1:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.is_hex = 1'b1;
      h.value  = '0;
      if (b >= "0" && b <= "9") begin
         h.value = HEX_BITS'(b - 8'h30);
      end else if (b >= "a" && b <= "f") begin
         h.value = HEX_BITS'(b - 8'h57);
      end else if (b >= "A" && b <= "F") begin
         h.value = HEX_BITS'(b - 8'h37);
      end else begin
         h.is_hex = 1'b0;
      end
      return h;
   endfunction

endpackage

// ----- src/hcbd_next.sv -----
// ----------------------------------------------------------------------------
// hcbd_next
// next-state and result logic for one body byte
// ----------------------------------------------------------------------------
module hcbd_next #(
   parameter int COUNT_WIDTH = 32
) (
   input  hcbd_pkg::flags_type       flags,
   input  logic [COUNT_WIDTH-1:0]    count,
   input  logic [7:0]                in_byte,
   output hcbd_pkg::flags_type       flags_next,
   output logic [COUNT_WIDTH-1:0]    count_next,
   output hcbd_pkg::result_type      result
);

   hcbd_pkg::hex_type      hex;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic                   line_done;

   always_comb begin
      hex        = hcbd_pkg::hex_decode(in_byte);
      count_dec  = count - COUNT_WIDTH'(1);
      line_done  = (in_byte == hcbd_pkg::CHAR_LF) && flags.cr_seen;
      flags_next = flags;
      count_next = count;
      result     = '0;
      result.byte_consumed = 1'b1;

      unique case (flags.phase)
         hcbd_pkg::PH_SIZE: begin
            if (!flags.digits_ended && hex.is_hex) begin
               if (|count[COUNT_WIDTH-1 -: hcbd_pkg::HEX_BITS]) begin
                  count_next          = '1;
                  flags_next.overflow = 1'b1;
               end else begin
                  count_next = {count[COUNT_WIDTH-hcbd_pkg::HEX_BITS-1:0], hex.value};
               end
               flags_next.cr_seen = 1'b0;
            end else begin
               flags_next.digits_ended = 1'b1;
               flags_next.cr_seen      = (in_byte == hcbd_pkg::CHAR_CR);
               if (line_done) begin
                  flags_next.cr_seen      = 1'b0;
                  flags_next.digits_ended = 1'b0;
                  flags_next.phase = (count == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
               end
            end
         end
         hcbd_pkg::PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = in_byte;
            count_next           = count_dec;
            if (count_dec == '0) begin
               flags_next.phase   = hcbd_pkg::PH_AFTER;
               flags_next.cr_seen = 1'b0;
            end
         end
         hcbd_pkg::PH_AFTER: begin
            flags_next.cr_seen = (in_byte == hcbd_pkg::CHAR_CR);
            if (line_done) begin
               flags_next.cr_seen      = 1'b0;
               flags_next.phase        = hcbd_pkg::PH_SIZE;
               flags_next.digits_ended = 1'b0;
               count_next              = '0;
            end
         end
         default: begin
            result.byte_consumed = 1'b0;
         end
      endcase

      result.finished      = (flags_next.phase == hcbd_pkg::PH_DONE);
      result.size_overflow = flags_next.overflow;
   end

endmodule

// ----- src/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// decodes an http/1.1 chunked body one byte per item
// ----------------------------------------------------------------------------
// an accepted req item shows up as its rsp item in the cycle after it is accepted
// throughput: one item per cycle unless a held result is stalled, set by the single state update per byte
// req_stall follows rsp_stall only while a result is held in the rsp register
// reset (synchronous, active high) returns to the size line with count zero
// and clears the overflow flag
module http_chunked_body_decoder #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_payload_valid,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_consumed,
   output logic       rsp_finished,
   output logic       rsp_size_overflow
);

   hcbd_pkg::flags_type    flags_ff, flags_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   hcbd_pkg::result_type   result_ff, result_in;
   logic                   valid_ff;
   logic                   accept;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   hcbd_next #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_next (
      .flags      (flags_ff),
      .count      (count_ff),
      .in_byte    (req_in_byte),
      .flags_next (flags_in),
      .count_next (count_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.phase        <= hcbd_pkg::PH_SIZE;
         flags_ff.digits_ended <= 1'b0;
         flags_ff.cr_seen      <= 1'b0;
         flags_ff.overflow     <= 1'b0;
         count_ff              <= '0;
         valid_ff              <= 1'b0;
      end else begin
         if (accept) begin
            flags_ff <= flags_in;
            count_ff <= count_in;
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_payload_valid = result_ff.payload_valid;
   assign rsp_payload_byte  = result_ff.payload_byte;
   assign rsp_byte_consumed = result_ff.byte_consumed;
   assign rsp_finished      = result_ff.finished;
   assign rsp_size_overflow = result_ff.size_overflow;

endmodule

// ----- src/hcbd_checker.sv -----
// ----------------------------------------------------------------------------
// hcbd_checker
// port-level checks for the chunked body decoder
// ----------------------------------------------------------------------------
module hcbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_payload_valid,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_byte_consumed,
   input logic       rsp_finished
);

   // held result stays valid and its payload byte stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte))
      else $error("rsp item changed while stalled");

   a_payload_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_byte_consumed)
      else $error("payload byte not marked consumed");

   a_unused_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_consumed |-> rsp_finished)
      else $error("byte left unused before finish");

   a_no_payload_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_payload_valid)
      else $error("payload after finish");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'h00)
      else $error("payload byte nonzero without payload");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_byte_consumed (rsp_byte_consumed),
   .rsp_finished      (rsp_finished)
);
